// ===== src/spn_pkg.sv =====
// Shared types, S-box tables and layer functions for the 16-bit SPN cipher.
package spn_pkg;

  localparam int unsigned BlockW = 16;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned NumCells = 4;

  typedef enum logic {
    ACT_ENCRYPT = 1'b0,
    ACT_DECRYPT = 1'b1
  } action_e;

  typedef logic [3:0] nibble_t;
  typedef logic [BlockW-1:0] block_t;

  localparam nibble_t FwdBox [16] = '{
    4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7
  };

  localparam nibble_t InvBox [16] = '{
    4'd14, 4'd3, 4'd4, 4'd8, 4'd1, 4'd12, 4'd10, 4'd15,
    4'd7, 4'd13, 4'd9, 4'd6, 4'd11, 4'd2, 4'd0, 4'd5
  };

  // Data handed from one cell to the next.
  typedef struct packed {
    logic    valid;
    action_e action;
    block_t  data;
  } stage_t;

  // Per-cell wiring: position in the chain and the round keys it uses.
  typedef struct packed {
    logic   is_first;
    logic   is_last;
    block_t enc_key;
    block_t enc_final_key;
    block_t dec_pre_key;
    block_t dec_key;
  } cell_ctrl_t;

  function automatic block_t sub_fwd(block_t x);
    block_t y;
    for (int n = 0; n < 4; n++) begin
      y[4*n +: 4] = FwdBox[x[4*n +: 4]];
    end
    return y;
  endfunction

  function automatic block_t sub_inv(block_t x);
    block_t y;
    for (int n = 0; n < 4; n++) begin
      y[4*n +: 4] = InvBox[x[4*n +: 4]];
    end
    return y;
  endfunction

  // Bit transpose, MSB-first numbering: out bit 4a+b takes in bit 4b+a.
  function automatic block_t perm(block_t x);
    block_t y;
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        y[15-(4*a+b)] = x[15-(4*b+a)];
      end
    end
    return y;
  endfunction

  function automatic block_t round_key(logic [KeyW-1:0] key, int unsigned r);
    return key[KeyW-1-4*r -: BlockW];
  endfunction

endpackage

// ===== src/spn_in_if.sv =====
// Request channel: operation and input block.
interface spn_in_if;
  import spn_pkg::*;
  logic    valid;
  logic    ready;
  action_e action;
  block_t  block_in;

  modport source (output valid, output action, output block_in, input ready);
  modport sink   (input valid, input action, input block_in, output ready);
endinterface

// ===== src/spn_out_if.sv =====
// Result channel: output block.
interface spn_out_if;
  import spn_pkg::*;
  logic   valid;
  logic   ready;
  block_t block_out;

  modport source (output valid, output block_out, input ready);
  modport sink   (input valid, input block_out, output ready);
endinterface

// ===== src/spn_16bit_block_cipher.sv =====
// Top level of the 16-bit SPN block cipher: key register and chain of round cells.
//
// Encrypts or decrypts one 16-bit block per request under a 32-bit key. Four
// round cells form a pipeline, one round per cell, so a result passes through
// every cell register in turn. While the chain advances, a new request is
// taken every cycle. The chain moves as a whole: it advances whenever the last
// cell is empty or its result is taken, so a stalled result holds every cell
// behind it. The key is written through cfg_we_i/cfg_wdata_i and resets to
// zero; write it only while no request is in flight.
module spn_16bit_block_cipher
  import spn_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  spn_in_if.sink          in_ch,
  spn_out_if.source       out_ch,
  input  logic            cfg_we_i,
  input  logic [KeyW-1:0] cfg_wdata_i
);

  logic [KeyW-1:0] key_q;
  logic            advance;
  stage_t          chain [NumCells+1];
  cell_ctrl_t      ctrl [NumCells];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      key_q <= cfg_wdata_i;
    end
  end

  // Advance when the last cell is empty or its result is taken.
  assign advance     = !chain[NumCells].valid || out_ch.ready;
  assign in_ch.ready = advance;

  assign chain[0].valid  = in_ch.valid;
  assign chain[0].action = in_ch.action;
  assign chain[0].data   = in_ch.block_in;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    assign ctrl[i].is_first      = (i == 0);
    assign ctrl[i].is_last       = (i == NumCells - 1);
    assign ctrl[i].enc_key       = round_key(key_q, i);
    assign ctrl[i].enc_final_key = round_key(key_q, NumCells);
    assign ctrl[i].dec_pre_key   = round_key(key_q, NumCells);
    assign ctrl[i].dec_key       = round_key(key_q, NumCells - 1 - i);

    spn_round_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .ctrl_i    (ctrl[i]),
      .stage_i   (chain[i]),
      .stage_o   (chain[i+1])
    );
  end

  assign out_ch.valid     = chain[NumCells].valid;
  assign out_ch.block_out = chain[NumCells].data;

endmodule

// ===== src/spn_round_cell.sv =====
// One round cell: a key/S-box/permutation round in either direction, registered.
module spn_round_cell
  import spn_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  cell_ctrl_t ctrl_i,
  input  stage_t     stage_i,
  output stage_t     stage_o
);

  logic   valid_q;
  action_e action_q;
  block_t data_q;
  block_t data_d;
  block_t sub_in;
  block_t sub_out;

  always_comb begin
    data_d = '0;
    sub_in = '0;
    sub_out = '0;
    case (stage_i.action)
      ACT_ENCRYPT: begin
        sub_out = sub_fwd(stage_i.data ^ ctrl_i.enc_key);
        data_d  = ctrl_i.is_last ? (sub_out ^ ctrl_i.enc_final_key) : perm(sub_out);
      end
      ACT_DECRYPT: begin
        sub_in  = ctrl_i.is_first ? (stage_i.data ^ ctrl_i.dec_pre_key) : perm(stage_i.data);
        sub_out = sub_inv(sub_in);
        data_d  = sub_out ^ ctrl_i.dec_key;
      end
      default: data_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      action_q <= stage_i.action;
      data_q   <= data_d;
    end
  end

  assign stage_o.valid  = valid_q;
  assign stage_o.action = action_q;
  assign stage_o.data   = data_q;

endmodule

// ===== dv/spn_cipher_checker.sv =====
// Passive checker for the SPN cipher: tracks the key, predicts each block and compares results.
`timescale 1ns / 1ps

module spn_cipher_checker
  import spn_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic            req_ready_i,
  input  action_e         req_action_i,
  input  block_t          req_block_i,
  input  logic            rsp_valid_i,
  input  logic            rsp_ready_i,
  input  block_t          rsp_block_i,
  input  logic            cfg_we_i,
  input  logic [KeyW-1:0] cfg_wdata_i,
  output int unsigned     pending_o,
  output int unsigned     fail_count_o
);

  localparam logic [3:0] SboxFwd [16] = '{
    4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
    4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
  };
  localparam logic [3:0] SboxInv [16] = '{
    4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
    4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5
  };

  logic [KeyW-1:0] cipher_key;
  block_t          expected_blocks [$];

  function automatic block_t subkey(logic [KeyW-1:0] k, int unsigned r);
    return block_t'(k >> (16 - 4 * r));
  endfunction

  function automatic block_t substitute(block_t x, logic inverse);
    block_t y;
    for (int n = 0; n < 4; n++) begin
      y[4*n +: 4] = inverse ? SboxInv[x[4*n +: 4]] : SboxFwd[x[4*n +: 4]];
    end
    return y;
  endfunction

  // Treat the block as a 4x4 bit matrix and transpose it.
  function automatic block_t transpose(block_t x);
    block_t y;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        y[4*i+j] = x[4*j+i];
      end
    end
    return y;
  endfunction

  function automatic block_t encipher(block_t p, logic [KeyW-1:0] k);
    block_t w;
    w = p;
    for (int r = 0; r < 3; r++) begin
      w = transpose(substitute(w ^ subkey(k, r), 1'b0));
    end
    w = substitute(w ^ subkey(k, 3), 1'b0);
    return w ^ subkey(k, 4);
  endfunction

  function automatic block_t decipher(block_t c, logic [KeyW-1:0] k);
    block_t w;
    w = substitute(c ^ subkey(k, 4), 1'b1) ^ subkey(k, 3);
    for (int r = 0; r < 3; r++) begin
      w = substitute(transpose(w), 1'b1) ^ subkey(k, 2 - r);
    end
    return w;
  endfunction

  // Inputs only change at rising edges, so the falling edge shows what the next edge takes.
  always @(negedge clk_i) begin
    block_t want;
    if (!rst_ni) begin
      cipher_key = '0;
      expected_blocks.delete();
    end else begin
      if (req_valid_i && req_ready_i) begin
        if (req_action_i == ACT_DECRYPT) begin
          expected_blocks.push_back(decipher(req_block_i, cipher_key));
        end else begin
          expected_blocks.push_back(encipher(req_block_i, cipher_key));
        end
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_blocks.size() == 0) begin
          fail_count_o++;
          $error("block_out: expected none, got %h", rsp_block_i);
        end else begin
          want = expected_blocks.pop_front();
          if (want !== rsp_block_i) begin
            fail_count_o++;
            $error("block_out: expected %h, got %h", want, rsp_block_i);
          end
        end
      end
      if (cfg_we_i) begin
        cipher_key = cfg_wdata_i;
      end
    end
    pending_o = expected_blocks.size();
  end

endmodule

// ===== dv/tb_spn_16bit_block_cipher.sv =====
// Testbench top for the SPN cipher: clock, reset, key phases, request and result traffic.
`timescale 1ns / 1ps

module tb_spn_16bit_block_cipher;
  import spn_pkg::*;

  localparam int unsigned ClkPeriod   = 12;
  localparam int unsigned IdlePct     = 28;
  localparam int unsigned PhaseItems  = 210;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned HoldCycles  = 90;
  localparam int unsigned LimitCycles = 200_000;

  localparam block_t CornerBlocks [6] = '{
    16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'hAAAA, 16'h5555
  };
  localparam logic [KeyW-1:0] FixedKeys [4] = '{
    32'h3A94_D63F, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001
  };

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [KeyW-1:0] cfg_wdata_i;
  logic            calm;
  logic            hold_ask;
  int unsigned     pending;
  int unsigned     fail_count;

  spn_in_if  in_ch ();
  spn_out_if out_ch ();

  spn_16bit_block_cipher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  spn_cipher_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (in_ch.valid),
    .req_ready_i  (in_ch.ready),
    .req_action_i (in_ch.action),
    .req_block_i  (in_ch.block_in),
    .rsp_valid_i  (out_ch.valid),
    .rsp_ready_i  (out_ch.ready),
    .rsp_block_i  (out_ch.block_out),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #(ClkPeriod * LimitCycles);
    $display("Mismatches found");
    $finish;
  end

  // Offer one request and hold it until taken; returns at the accepting edge.
  task automatic send_request(action_e act, block_t blk);
    if (!calm) begin
      while ($urandom_range(99) < IdlePct) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.block_in <= blk;
    forever begin
      @(negedge clk_i);
      if (in_ch.ready) begin
        break;
      end
    end
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_key(logic [KeyW-1:0] k);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Result side: random stalls, one long hold-off on request.
  initial begin
    int unsigned hold_left;
    logic        hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      // Start the hold-off on the rising edge of the ask.
      if (hold_ask && !hold_seen && hold_left == 0) begin
        hold_left = HoldCycles;
      end
      hold_seen = hold_ask;
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IdlePct);
      end
    end
  end

  initial begin
    logic [KeyW-1:0] key;
    calm           = 1'b0;
    hold_ask       = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_ch.valid    = 1'b0;
    in_ch.action   = ACT_ENCRYPT;
    in_ch.block_in = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner blocks under the reset key, both directions.
    foreach (CornerBlocks[i]) begin
      send_request(ACT_ENCRYPT, CornerBlocks[i]);
      send_request(ACT_DECRYPT, CornerBlocks[i]);
    end
    drain_results();
    load_key(32'hFFFF_FFFF);
    send_request(ACT_ENCRYPT, 16'h0000);
    send_request(ACT_DECRYPT, 16'h0000);
    send_request(ACT_ENCRYPT, 16'hFFFF);
    send_request(ACT_DECRYPT, 16'hFFFF);
    drain_results();

    for (int p = 0; p < NumPhases; p++) begin
      key = (p < 4) ? FixedKeys[p] : $urandom();
      load_key(key);
      calm = (p == 3);
      for (int n = 0; n < PhaseItems; n++) begin
        // Stall the result side long enough to back the pipeline up.
        if (p == 1 && n == 40) begin
          hold_ask = 1'b1;
        end
        // Pause requests until every result is out.
        if (p == 2 && n == 100) begin
          drain_results();
        end
        send_request(action_e'($urandom_range(1)), block_t'($urandom()));
      end
      drain_results();
    end
    calm = 1'b0;

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
